FILE: rtl/ats_pkg.sv
// Shared types and constants for the aging task selector.
// No dependencies; used by ats_ram users and the top level by scoped names.
package ats_pkg;

   localparam int SLOTS        = 32;
   localparam int COUNT_WIDTH  = 16;
   localparam int IDX_W        = $clog2(SLOTS);
   localparam int SWEEP_W      = $clog2(SLOTS + 1);
   localparam int STATUS_W     = 2;
   localparam int CMD_W        = 3;
   localparam int SLOT_FIELD_W = 5;
   localparam int OUTCOME_W    = 2;
   localparam int CSR_W        = 16;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic [SWEEP_W-1:0]      sweep_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [STATUS_W-1:0]     status_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_field_type;
   typedef logic [CSR_W-1:0]        csr_type;

   localparam count_type  COUNT_MAX      = '1;
   localparam sweep_type  SWEEP_END      = SWEEP_W'(SLOTS);
   localparam csr_type    MAX_PRIO_RESET = CSR_W'(16);

   // slot status codes
   localparam status_type ST_WAITING = 2'd0;
   localparam status_type ST_RUNNING = 2'd1;
   localparam status_type ST_YIELDED = 2'd2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REQUEUE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd4;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_SWITCHED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_KEPT     = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_IDLE     = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_DONE     = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      slot_field_type   slot;
      logic             start_waiting;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      slot_field_type       chosen_slot;
      slot_field_type       previous_slot;
      logic                 previous_saved;
   } rsp_type;

endpackage

FILE: rtl/ats_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ats_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/aging_task_selector.sv
// Top level of the aging task selector: command decode, slot sweep, result register.
// Depends on ats_pkg and two ats_ram instances (slot status and idle count).
//
// Aging task selector. A command word is taken at a clock edge where start is high
// and busy is low; its result word appears on rsp_word for exactly one cycle with
// rsp_strobe high, and the receiver cannot stall it. Create, dequeue, requeue and
// remove finish in the accept cycle: busy stays low, the next word may follow in the
// next cycle, and the result shows in the cycle after the accept. Schedule walks the
// slot table once through the count and status memories, one slot per cycle: it
// keeps busy high through the sweep and the decide state, and the finish state on a
// switch; its result shows in the cycle busy drops. The sweep length is set by the
// single read port of each memory, used once per slot. Valid bits live in flip-flops
// cleared by reset, so no clearing pass is needed. The user must write max_priority
// through csr_wr_en/csr_wr_data only while idle; the block itself does not enforce this.
module aging_task_selector (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ats_pkg::req_type req_word,
   output logic             rsp_strobe,
   output ats_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  ats_pkg::csr_type csr_wr_data
);

   // state codes
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]             state_ff, state_in;
   ats_pkg::sweep_type     sweep_cnt_ff, sweep_cnt_in;
   logic                   pend_ff, pend_in;
   ats_pkg::idx_type       pend_idx_ff, pend_idx_in;
   ats_pkg::idx_type       best_idx_ff, best_idx_in;
   ats_pkg::count_type     best_cnt_ff, best_cnt_in;
   logic                   found_ff, found_in;
   ats_pkg::status_type    cur_status_ff, cur_status_in;
   ats_pkg::idx_type       current_slot_ff, current_slot_in;
   logic                   current_valid_ff, current_valid_in;
   logic [ats_pkg::SLOTS-1:0] slot_valid_ff, slot_valid_in;
   ats_pkg::csr_type       max_prio_ff, max_prio_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   ats_pkg::rsp_type       rsp_word_ff, rsp_word_in;

   // memory ports
   logic                   stat_we;
   ats_pkg::idx_type       stat_waddr;
   ats_pkg::status_type    stat_wdata;
   ats_pkg::status_type    stat_rdata;
   logic                   cnt_we;
   ats_pkg::idx_type       cnt_waddr;
   ats_pkg::count_type     cnt_wdata;
   ats_pkg::count_type     cnt_rdata;
   ats_pkg::idx_type       rd_addr;

   logic                   accept;
   logic                   in_range;
   ats_pkg::idx_type       req_idx;
   logic                   req_slot_valid;
   ats_pkg::count_type     requeue_cnt;
   ats_pkg::count_type     aged_cnt;

   ats_ram #(
      .WIDTH (ats_pkg::STATUS_W),
      .DEPTH (ats_pkg::SLOTS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_addr (rd_addr),
      .rd_data (stat_rdata)
   );

   ats_ram #(
      .WIDTH (ats_pkg::COUNT_WIDTH),
      .DEPTH (ats_pkg::SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && (state_ff == ST_IDLE);
   assign in_range   = (32'(req_word.slot) < 32'(ats_pkg::SLOTS));
   assign req_idx    = ats_pkg::idx_type'(req_word.slot);
   assign req_slot_valid = in_range && slot_valid_ff[req_idx];
   assign rd_addr    = sweep_cnt_ff[ats_pkg::IDX_W-1:0];

   // clamp the requeue boost to what the counter can hold
   assign requeue_cnt = (32'(max_prio_ff) < 32'(ats_pkg::COUNT_MAX)) ?
                        ats_pkg::count_type'(max_prio_ff) : ats_pkg::COUNT_MAX;

   // age by one, saturating
   assign aged_cnt = (cnt_rdata == ats_pkg::COUNT_MAX) ? cnt_rdata :
                     cnt_rdata + ats_pkg::count_type'(1);

   always_comb begin
      state_in         = state_ff;
      sweep_cnt_in     = sweep_cnt_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      best_idx_in      = best_idx_ff;
      best_cnt_in      = best_cnt_ff;
      found_in         = found_ff;
      cur_status_in    = cur_status_ff;
      current_slot_in  = current_slot_ff;
      current_valid_in = current_valid_ff;
      slot_valid_in    = slot_valid_ff;
      max_prio_in      = csr_wr_en ? csr_wr_data : max_prio_ff;
      rsp_strobe_in    = 1'b0;
      rsp_word_in      = '0;
      stat_we          = 1'b0;
      stat_waddr       = req_idx;
      stat_wdata       = ats_pkg::ST_WAITING;
      cnt_we           = 1'b0;
      cnt_waddr        = req_idx;
      cnt_wdata        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.command == ats_pkg::CMD_SCHEDULE) begin
                  // launch the sweep at slot 0
                  state_in     = ST_SWEEP;
                  sweep_cnt_in = '0;
                  pend_in      = 1'b0;
                  found_in     = 1'b0;
                  best_cnt_in  = '0;
                  best_idx_in  = '0;
               end else begin
                  // single-slot updates finish here; unknown codes just report done
                  rsp_strobe_in       = 1'b1;
                  rsp_word_in.outcome = ats_pkg::OUT_DONE;
                  priority case (req_word.command)
                     ats_pkg::CMD_CREATE: begin
                        if (in_range) begin
                           slot_valid_in[req_idx] = 1'b1;
                           stat_we    = 1'b1;
                           stat_wdata = req_word.start_waiting ? ats_pkg::ST_WAITING
                                                               : ats_pkg::ST_YIELDED;
                           cnt_we     = 1'b1;
                           cnt_wdata  = '0;
                        end
                     end
                     ats_pkg::CMD_DEQUEUE: begin
                        if (req_slot_valid) begin
                           stat_we    = 1'b1;
                           stat_wdata = ats_pkg::ST_YIELDED;
                        end
                     end
                     ats_pkg::CMD_REQUEUE: begin
                        if (req_slot_valid) begin
                           stat_we    = 1'b1;
                           stat_wdata = ats_pkg::ST_WAITING;
                           cnt_we     = 1'b1;
                           cnt_wdata  = requeue_cnt;
                        end
                     end
                     ats_pkg::CMD_REMOVE: begin
                        if (in_range) begin
                           slot_valid_in[req_idx] = 1'b0;
                           if (current_valid_ff && (current_slot_ff == req_idx)) begin
                              current_valid_in = 1'b0;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_SWEEP: begin
            // issue the next read while the previous slot's data is processed
            if (sweep_cnt_ff != ats_pkg::SWEEP_END) begin
               pend_in      = 1'b1;
               pend_idx_in  = rd_addr;
               sweep_cnt_in = sweep_cnt_ff + ats_pkg::sweep_type'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_DECIDE;
            end
            if (pend_ff) begin
               if (pend_idx_ff == current_slot_ff) begin
                  cur_status_in = stat_rdata;
               end
               if (slot_valid_ff[pend_idx_ff]) begin
                  cnt_we    = 1'b1;
                  cnt_waddr = pend_idx_ff;
                  cnt_wdata = aged_cnt;
                  if ((stat_rdata == ats_pkg::ST_WAITING) && (best_cnt_in < aged_cnt)) begin
                     best_cnt_in = aged_cnt;
                     best_idx_in = pend_idx_ff;
                     found_in    = 1'b1;
                  end
               end
            end
         end

         ST_DECIDE: begin
            if (!found_ff) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               if (current_valid_ff) begin
                  rsp_word_in.outcome     = ats_pkg::OUT_KEPT;
                  rsp_word_in.chosen_slot = ats_pkg::slot_field_type'(current_slot_ff);
               end else begin
                  rsp_word_in.outcome = ats_pkg::OUT_IDLE;
               end
            end else begin
               // send the outgoing task back to waiting unless it yielded
               state_in = ST_FINISH;
               if (current_valid_ff) begin
                  stat_we    = 1'b1;
                  stat_waddr = current_slot_ff;
                  stat_wdata = (cur_status_ff == ats_pkg::ST_YIELDED) ? ats_pkg::ST_YIELDED
                                                                      : ats_pkg::ST_WAITING;
               end
            end
         end

         ST_FINISH: begin
            // install the winner; this write lands after the outgoing one
            state_in         = ST_IDLE;
            stat_we          = 1'b1;
            stat_waddr       = best_idx_ff;
            stat_wdata       = ats_pkg::ST_RUNNING;
            cnt_we           = 1'b1;
            cnt_waddr        = best_idx_ff;
            cnt_wdata        = '0;
            current_slot_in  = best_idx_ff;
            current_valid_in = 1'b1;
            rsp_strobe_in    = 1'b1;
            rsp_word_in.outcome     = ats_pkg::OUT_SWITCHED;
            rsp_word_in.chosen_slot = ats_pkg::slot_field_type'(best_idx_ff);
            if (current_valid_ff) begin
               rsp_word_in.previous_slot  = ats_pkg::slot_field_type'(current_slot_ff);
               rsp_word_in.previous_saved = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pend_ff          <= 1'b0;
         found_ff         <= 1'b0;
         current_slot_ff  <= '0;
         current_valid_ff <= 1'b0;
         slot_valid_ff    <= '0;
         max_prio_ff      <= ats_pkg::MAX_PRIO_RESET;
         rsp_strobe_ff    <= 1'b0;
         sweep_cnt_ff     <= '0;
      end else begin
         state_ff         <= state_in;
         pend_ff          <= pend_in;
         found_ff         <= found_in;
         current_slot_ff  <= current_slot_in;
         current_valid_ff <= current_valid_in;
         slot_valid_ff    <= slot_valid_in;
         max_prio_ff      <= max_prio_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         sweep_cnt_ff     <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_cnt_ff   <= best_cnt_in;
      cur_status_ff <= cur_status_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // the aging write-back never targets the slot being read in the same cycle
   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && cnt_we) |-> (cnt_waddr != rd_addr))
      else $error("sweep write-back collides with sweep read");

   // a single-slot update reports in the very next cycle
   a_update_reports: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.command != ats_pkg::CMD_SCHEDULE) |=>
         (rsp_strobe && rsp_word.outcome == ats_pkg::OUT_DONE))
      else $error("update result missing");

   // a switch leaves the chosen slot as the current task
   a_switch_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.outcome == ats_pkg::OUT_SWITCHED) |->
         (current_valid_ff &&
          ats_pkg::slot_field_type'(current_slot_ff) == rsp_word.chosen_slot))
      else $error("switched result does not match current task");

endmodule

FILE: tb/ats_checker.sv
// Result checker for the aging task selector: keeps its own copy of the slot table.
// It predicts every result word and compares it with what the block returns.
// Depends on ats_pkg for the word types and the command, status and outcome codes.
module ats_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  ats_pkg::req_type req_word,
   input  logic             rsp_strobe,
   input  ats_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  ats_pkg::csr_type csr_wr_data,
   output int               fail_count,
   output int               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                slot_live [ats_pkg::SLOTS];
   ats_pkg::status_type slot_state [ats_pkg::SLOTS];
   ats_pkg::count_type  slot_age [ats_pkg::SLOTS];
   ats_pkg::idx_type    run_slot;
   logic                run_valid;
   ats_pkg::csr_type    requeue_age;
   ats_pkg::rsp_type    awaited_results [$];
   int                  errors = 0;

   // Advance the slot table by one command word and return the result it earns.
   function automatic ats_pkg::rsp_type apply_command(ats_pkg::req_type w);
      ats_pkg::rsp_type   r;
      ats_pkg::idx_type   best;
      ats_pkg::count_type best_cnt;
      bit                 found;
      ats_pkg::idx_type   s;
      r         = '0;
      r.outcome = ats_pkg::OUT_DONE;
      s         = ats_pkg::idx_type'(w.slot);
      best      = '0;
      best_cnt  = '0;
      found     = 1'b0;
      case (w.command)
         ats_pkg::CMD_SCHEDULE: begin
            for (int i = 0; i < ats_pkg::SLOTS; i++) begin
               if (slot_live[i]) begin
                  if (slot_age[i] != ats_pkg::COUNT_MAX) slot_age[i] = slot_age[i] + 1'b1;
                  if (slot_state[i] == ats_pkg::ST_WAITING && best_cnt < slot_age[i]) begin
                     best_cnt = slot_age[i];
                     best     = ats_pkg::idx_type'(i);
                     found    = 1'b1;
                  end
               end
            end
            if (!found) begin
               if (run_valid) begin
                  r.outcome     = ats_pkg::OUT_KEPT;
                  r.chosen_slot = run_slot;
               end else begin
                  r.outcome = ats_pkg::OUT_IDLE;
               end
            end else begin
               if (run_valid) begin
                  if (slot_state[run_slot] != ats_pkg::ST_YIELDED)
                     slot_state[run_slot] = ats_pkg::ST_WAITING;
                  r.previous_slot  = run_slot;
                  r.previous_saved = 1'b1;
               end
               slot_age[best]   = '0;
               slot_state[best] = ats_pkg::ST_RUNNING;
               run_slot         = best;
               run_valid        = 1'b1;
               r.outcome        = ats_pkg::OUT_SWITCHED;
               r.chosen_slot    = best;
            end
         end
         ats_pkg::CMD_CREATE: begin
            slot_live[s]  = 1'b1;
            slot_state[s] = w.start_waiting ? ats_pkg::ST_WAITING : ats_pkg::ST_YIELDED;
            slot_age[s]   = '0;
         end
         ats_pkg::CMD_DEQUEUE: begin
            if (slot_live[s]) slot_state[s] = ats_pkg::ST_YIELDED;
         end
         ats_pkg::CMD_REQUEUE: begin
            if (slot_live[s]) begin
               slot_state[s] = ats_pkg::ST_WAITING;
               slot_age[s]   = ats_pkg::count_type'(requeue_age);
            end
         end
         ats_pkg::CMD_REMOVE: begin
            slot_live[s] = 1'b0;
            if (run_valid && run_slot == s) run_valid = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : watch
      ats_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < ats_pkg::SLOTS; i++) slot_live[i] = 1'b0;
         run_slot    = '0;
         run_valid   = 1'b0;
         requeue_age = ats_pkg::MAX_PRIO_RESET;
         awaited_results.delete();
      end else begin
         if (csr_wr_en) requeue_age = csr_wr_data;
         // Drain before fill: a word's result never shows in its own accept cycle.
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t ns: result word with none awaited, expected none, actual %h",
                        $time, rsp_word);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_word.outcome !== want.outcome)
                  flag("outcome", 16'(want.outcome), 16'(rsp_word.outcome));
               if (rsp_word.chosen_slot !== want.chosen_slot)
                  flag("chosen_slot", 16'(want.chosen_slot), 16'(rsp_word.chosen_slot));
               if (rsp_word.previous_slot !== want.previous_slot)
                  flag("previous_slot", 16'(want.previous_slot), 16'(rsp_word.previous_slot));
               if (rsp_word.previous_saved !== want.previous_saved)
                  flag("previous_saved", 16'(want.previous_saved),
                       16'(rsp_word.previous_saved));
            end
         end
         if (start && !busy) awaited_results.push_back(apply_command(req_word));
      end
      fail_count  <= errors;
      outstanding <= awaited_results.size();
   end

endmodule

FILE: tb/tb_aging_task_selector.sv
// Testbench top for the aging task selector: clock, reset, command words and verdict.
// Depends on ats_pkg, the aging_task_selector block and the ats_checker module.
module tb_aging_task_selector;
   timeunit 1ns;
   timeprecision 1ps;

   // Highest defined command; anything above it must be answered as a plain update.
   localparam logic [ats_pkg::CMD_W-1:0] CMD_LAST = ats_pkg::CMD_REMOVE;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 225;
   // Cycles with no accepted or returned word before the run is declared hung. This is
   // many times the longest busy stretch of a schedule and the longest sender gap.
   localparam int STALL_LIMIT = 1000;
   // Longest busy stretch plus the result cycle, with margin.
   localparam int DRAIN_CYCLES = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ats_pkg::req_type req_word = '0;
   logic             rsp_strobe;
   ats_pkg::rsp_type rsp_word;
   logic             csr_wr_en = 1'b0;
   ats_pkg::csr_type csr_wr_data = '0;
   int               fail_count;
   int               outstanding;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   aging_task_selector uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ats_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic ats_pkg::req_type cmd_word(logic [ats_pkg::CMD_W-1:0] c,
                                                 int unsigned s, bit w);
      ats_pkg::req_type r;
      r.command       = c;
      r.slot          = ats_pkg::slot_field_type'(s);
      r.start_waiting = w;
      return r;
   endfunction

   // Mostly back-to-back words, some short gaps, a few long ones.
   function automatic int pick_gap(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one word and hold it until the block takes it. Called right after a
   // rising edge; returns at the edge that accepted the word.
   task automatic send_word(ats_pkg::req_type w);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start, put noise on the idle word and let the gap run out.
   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start    <= 1'b0;
         req_word <= ats_pkg::req_type'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Write max_priority only once the block is idle and every result is back.
   task automatic write_max_priority(ats_pkg::csr_type v);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= ats_pkg::csr_type'($urandom);
   endtask

   initial begin : stimulus
      ats_pkg::req_type directed [$];
      ats_pkg::req_type w;
      int unsigned      r;
      int unsigned      pool_lo;
      int               counted;
      bit               steady;
      ats_pkg::csr_type prio;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the selection rules, at the reset value of max_priority.
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // empty table: idle
      directed.push_back(cmd_word(ats_pkg::CMD_CREATE, 0, 1'b1));
      directed.push_back(cmd_word(ats_pkg::CMD_CREATE, 31, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_CREATE, 5, 1'b1));
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // tie: lowest slot wins
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // older waiter takes over
      directed.push_back(cmd_word(ats_pkg::CMD_DEQUEUE, 5, 1'b0));   // running task yields
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // yielded one stays yielded
      directed.push_back(cmd_word(ats_pkg::CMD_REQUEUE, 31, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_REQUEUE, 0, 1'b0));   // requeue the running task
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // current task picked again
      directed.push_back(cmd_word(ats_pkg::CMD_REMOVE, 0, 1'b0));    // remove the running task
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // switch with nothing saved
      directed.push_back(cmd_word(ats_pkg::CMD_DEQUEUE, 7, 1'b1));   // absent slots: ignored
      directed.push_back(cmd_word(ats_pkg::CMD_REQUEUE, 9, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_REMOVE, 12, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_CREATE, 31, 1'b1));   // set up a live slot anew
      directed.push_back(cmd_word(ats_pkg::CMD_DEQUEUE, 31, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 0, 1'b0));  // nothing waiting: keep
      directed.push_back(cmd_word(ats_pkg::CMD_REMOVE, 31, 1'b1));
      directed.push_back(cmd_word(ats_pkg::CMD_REMOVE, 5, 1'b0));
      directed.push_back(cmd_word(ats_pkg::CMD_SCHEDULE, 31, 1'b1)); // nothing at all: idle
      for (int k = 1; k <= 3; k++)                                   // undefined commands
         directed.push_back(cmd_word(CMD_LAST + ats_pkg::CMD_W'(k), 31, 1'b1));

      foreach (directed[i]) begin
         send_word(directed[i]);
         idle_for(pick_gap(i < 8));
      end

      // Random phases, each at its own max_priority; extremes first.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       prio = '0;
            1:       prio = '1;
            2:       prio = ats_pkg::csr_type'(1);
            3:       prio = ats_pkg::MAX_PRIO_RESET;
            default: prio = ats_pkg::csr_type'($urandom_range(0, 65535));
         endcase
         write_max_priority(prio);
         // Aim most words at a small window of slots so tasks live long enough
         // to age, tie and be switched; the rest roam the whole table.
         pool_lo = $urandom_range(0, 26);
         steady  = (p % 3 == 1);
         counted = 0;
         while (counted < PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            w.slot = ($urandom_range(0, 9) < 7) ?
                     ats_pkg::slot_field_type'($urandom_range(pool_lo, pool_lo + 5)) :
                     ats_pkg::slot_field_type'($urandom_range(0, 31));
            w.start_waiting = $urandom_range(0, 1);
            if (r < 22)      w.command = ats_pkg::CMD_SCHEDULE;
            else if (r < 47) w.command = ats_pkg::CMD_CREATE;
            else if (r < 60) w.command = ats_pkg::CMD_DEQUEUE;
            else if (r < 78) w.command = ats_pkg::CMD_REQUEUE;
            else if (r < 95) w.command = ats_pkg::CMD_REMOVE;
            else             w.command = CMD_LAST + ats_pkg::CMD_W'($urandom_range(1, 3));
            send_word(w);
            // Undefined commands change nothing; keep them out of the count.
            if (w.command <= CMD_LAST) counted++;
            idle_for(pick_gap(steady));
         end
      end

      // Drain: every result back, then the block's own latency once more.
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[aging_task_selector] OK");
      else
         $display("[aging_task_selector] ERROR");
      $finish;
   end

   // Watchdog: end the run if neither side moves a word for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      do begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end while (quiet < STALL_LIMIT);
      $display("[aging_task_selector] ERROR");
      $finish;
   end

endmodule
